### sv/drawing_language_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// drawing_language_tokenizer_macros
// Assertion macros used by the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef DRAWING_LANGUAGE_TOKENIZER_MACROS_SVH
`define DRAWING_LANGUAGE_TOKENIZER_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define DLT_ASSERT_IMPLY(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define DLT_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### sv/dlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlt_pkg
// Types, constants and keyword tables for the drawing language tokenizer.
// ----------------------------------------------------------------------------
package dlt_pkg;

    localparam int LOOKAHEAD_DEPTH = 64;
    localparam int KEYWORD_COUNT   = 7;
    localparam int CNT_W           = $clog2(LOOKAHEAD_DEPTH + 1);
    localparam int BUF_AW          = $clog2(LOOKAHEAD_DEPTH);
    localparam int BUF_SIZE        = 2 ** BUF_AW;
    localparam int LEN_W           = 7;

    localparam logic [3:0] K_BAD     = 4'd7;
    localparam logic [3:0] K_COMMENT = 4'd8;
    localparam logic [3:0] K_IDENT   = 4'd9;
    localparam logic [3:0] K_NUMBER  = 4'd10;
    localparam logic [3:0] K_STRING  = 4'd11;
    localparam logic [3:0] K_POUND   = 4'd12;
    localparam logic [3:0] K_PERIOD  = 4'd13;
    localparam logic [3:0] K_EQUALS  = 4'd14;
    localparam logic [3:0] K_EOF     = 4'd15;

    // Keywords are right aligned; character 0 sits in the highest used byte.
    localparam logic [63:0] KW_TEXT [KEYWORD_COUNT] = '{
        64'("#Version"), 64'("#Name"), 64'("#Author"), 64'("#Drawing"),
        64'("#Region"), 64'("#Circle"), 64'("#Rect")
    };
    localparam logic [3:0] KW_LEN [KEYWORD_COUNT] = '{
        4'd8, 4'd5, 4'd7, 4'd8, 4'd7, 4'd7, 4'd5
    };

    typedef enum logic [3:0] {
        M_IDLE, M_KEYWORD, M_STRING, M_STAR, M_BLOCK, M_BLOCK_STAR,
        M_LINE, M_NUMBER, M_IDENT
    } t_mode;

    typedef enum logic [1:0] {
        ACT_APPEND, ACT_CONSUME, ACT_BACK
    } t_act;

    typedef struct packed {
        t_act                     act;
        logic                     emit;
        logic [3:0]               kind;
        logic [CNT_W-1:0]         len;
        logic                     ovf;
        t_mode                    nmode;
        logic [KEYWORD_COUNT-1:0] nalive;
        logic [1:0]               nfs;
    } t_decision;

    typedef struct packed {
        logic [3:0]       kind;
        logic [31:0]      start;
        logic [CNT_W-1:0] len;
        logic             ovf;
    } t_token;

    function automatic logic [7:0] kw_char(input int idx, input logic [3:0] pos);
        logic [63:0] w;
        logic [3:0]  sh;
        w  = KW_TEXT[idx];
        sh = KW_LEN[idx] - 4'd1 - pos;
        return w[{sh[2:0], 3'b000} +: 8];
    endfunction

endpackage

### sv/dlt_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlt_channels
// Handshake channels for text bytes in and tokens out.
// ----------------------------------------------------------------------------
interface dlt_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface dlt_token_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_kind;
    logic [31:0] token_start;
    logic [6:0] token_length;
    logic       lookahead_overflow;
    logic       last_of_run;
    modport source (output valid, output token_kind, output token_start,
                    output token_length, output lookahead_overflow,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input lookahead_overflow,
                    input last_of_run, output ready);
endinterface

### sv/dlt_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlt_decide
// Judges one byte against the scan state and picks the buffer action.
// ----------------------------------------------------------------------------
module dlt_decide (
    input  logic [7:0]                        i_byte,
    input  dlt_pkg::t_mode                    i_mode,
    input  logic [dlt_pkg::CNT_W-1:0]         i_cnt,
    input  logic [dlt_pkg::KEYWORD_COUNT-1:0] i_alive,
    input  logic [1:0]                        i_fs,
    output dlt_pkg::t_decision                o_dec
);

    logic is_digit, is_lower, is_upper, is_space, is_end;
    logic [dlt_pkg::KEYWORD_COUNT-1:0] filt;
    dlt_pkg::t_decision d;
    logic [3:0] prov;

    assign is_digit = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign is_lower = (i_byte >= 8'h61) && (i_byte <= 8'h7a);
    assign is_upper = (i_byte >= 8'h41) && (i_byte <= 8'h5a);
    assign is_space = (i_byte == 8'h20) || (i_byte == 8'h0a) || (i_byte == 8'h09) ||
                      (i_byte == 8'h08) || (i_byte == 8'h0c) || (i_byte == 8'h0b);
    assign is_end   = (i_byte == 8'h00) || (i_byte == 8'h0a);

    always_comb begin
        for (int i = 0; i < dlt_pkg::KEYWORD_COUNT; i++) begin
            filt[i] = i_alive[i] && (i_cnt < dlt_pkg::CNT_W'(9)) &&
                      ({{(dlt_pkg::CNT_W-1){1'b0}}, 1'b0} + dlt_pkg::CNT_W'(dlt_pkg::KW_LEN[i])
                       > i_cnt) &&
                      (dlt_pkg::kw_char(i, i_cnt[3:0]) == i_byte);
        end
    end

    always_comb begin
        unique case (i_mode)
            dlt_pkg::M_STRING:                         prov = dlt_pkg::K_STRING;
            dlt_pkg::M_STAR, dlt_pkg::M_LINE,
            dlt_pkg::M_BLOCK, dlt_pkg::M_BLOCK_STAR:   prov = dlt_pkg::K_COMMENT;
            dlt_pkg::M_NUMBER:                         prov = dlt_pkg::K_NUMBER;
            dlt_pkg::M_IDENT:                          prov = dlt_pkg::K_IDENT;
            default:                                   prov = dlt_pkg::K_POUND;
        endcase
    end

    always_comb begin
        d        = '0;
        d.act    = dlt_pkg::ACT_APPEND;
        d.emit   = 1'b0;
        d.kind   = dlt_pkg::K_BAD;
        d.len    = dlt_pkg::CNT_W'(1);
        d.ovf    = 1'b0;
        d.nmode  = i_mode;
        d.nalive = i_alive;
        d.nfs    = i_fs;
        unique case (i_mode)
            dlt_pkg::M_KEYWORD: begin
                if ((i_cnt == dlt_pkg::CNT_W'(1)) ? is_upper : is_lower) begin
                    d.nalive = filt;
                    if (filt == '0) begin
                        d.act  = dlt_pkg::ACT_BACK;
                        d.kind = dlt_pkg::K_POUND;
                    end
                end else begin
                    d.act  = dlt_pkg::ACT_BACK;
                    d.kind = dlt_pkg::K_POUND;
                    // Lowest-numbered matching keyword wins.
                    for (int i = dlt_pkg::KEYWORD_COUNT - 1; i >= 0; i--) begin
                        if (i_alive[i] && dlt_pkg::CNT_W'(dlt_pkg::KW_LEN[i]) == i_cnt) begin
                            d.kind = 4'(i);
                            d.len  = i_cnt;
                        end
                    end
                end
            end
            dlt_pkg::M_STRING: begin
                if (i_byte == 8'h5d) begin
                    d.act  = dlt_pkg::ACT_CONSUME;
                    d.kind = dlt_pkg::K_STRING;
                end else if (is_end) begin
                    d.act  = dlt_pkg::ACT_BACK;
                end
            end
            dlt_pkg::M_STAR: begin
                if (i_byte == 8'h2a) begin
                    d.nmode = dlt_pkg::M_BLOCK;
                end else if (is_end) begin
                    d.act  = dlt_pkg::ACT_BACK;
                    d.kind = dlt_pkg::K_COMMENT;
                    d.len  = i_cnt;
                end else begin
                    d.nmode = dlt_pkg::M_LINE;
                end
            end
            dlt_pkg::M_LINE: begin
                if (is_end) begin
                    d.act  = dlt_pkg::ACT_BACK;
                    d.kind = dlt_pkg::K_COMMENT;
                    d.len  = i_cnt;
                end
            end
            dlt_pkg::M_BLOCK: begin
                if (i_byte == 8'h00) d.act = dlt_pkg::ACT_BACK;
                else if (i_byte == 8'h2a) d.nmode = dlt_pkg::M_BLOCK_STAR;
            end
            dlt_pkg::M_BLOCK_STAR: begin
                if (i_byte == 8'h2a) begin
                    d.act  = dlt_pkg::ACT_CONSUME;
                    d.kind = dlt_pkg::K_COMMENT;
                end else if (i_byte == 8'h00) begin
                    d.act = dlt_pkg::ACT_BACK;
                end else begin
                    d.nmode = dlt_pkg::M_BLOCK;
                end
            end
            dlt_pkg::M_NUMBER: begin
                priority if (i_fs == 2'd0) begin
                    if (i_byte == 8'h2e) begin
                        d.nfs = 2'd1;
                    end else if (!is_digit) begin
                        d.act  = dlt_pkg::ACT_BACK;
                        d.kind = dlt_pkg::K_NUMBER;
                        d.len  = i_cnt;
                    end
                end else if (i_fs == 2'd1) begin
                    if (is_digit) begin
                        d.nfs = 2'd2;
                    end else begin
                        // The dot is handed back for rescanning.
                        d.act  = dlt_pkg::ACT_BACK;
                        d.kind = dlt_pkg::K_NUMBER;
                        d.len  = (i_cnt > dlt_pkg::CNT_W'(1)) ? i_cnt - dlt_pkg::CNT_W'(1)
                                                              : dlt_pkg::CNT_W'(1);
                    end
                end else begin
                    if (!is_digit) begin
                        d.act  = dlt_pkg::ACT_BACK;
                        d.kind = dlt_pkg::K_NUMBER;
                        d.len  = i_cnt;
                    end
                end
            end
            dlt_pkg::M_IDENT: begin
                if (!is_lower) begin
                    d.act  = dlt_pkg::ACT_BACK;
                    d.kind = dlt_pkg::K_IDENT;
                    d.len  = i_cnt;
                end
            end
            default: begin
                priority if (is_space) begin
                    d.act = dlt_pkg::ACT_CONSUME;
                end else if (i_byte == 8'h23) begin
                    d.nmode = dlt_pkg::M_KEYWORD;
                end else if (i_byte == 8'h5b) begin
                    d.nmode = dlt_pkg::M_STRING;
                end else if (i_byte == 8'h2a) begin
                    d.nmode = dlt_pkg::M_STAR;
                end else if (i_byte == 8'h00) begin
                    d.act  = dlt_pkg::ACT_CONSUME;
                    d.emit = 1'b1;
                    d.kind = dlt_pkg::K_EOF;
                end else if (i_byte == 8'h3d) begin
                    d.act  = dlt_pkg::ACT_CONSUME;
                    d.emit = 1'b1;
                    d.kind = dlt_pkg::K_EQUALS;
                end else if (i_byte == 8'h2e) begin
                    d.act  = dlt_pkg::ACT_CONSUME;
                    d.emit = 1'b1;
                    d.kind = dlt_pkg::K_PERIOD;
                end else if (is_digit || i_byte == 8'h2b || i_byte == 8'h2d) begin
                    d.nmode = dlt_pkg::M_NUMBER;
                    d.nfs   = 2'd0;
                end else if (is_lower) begin
                    d.nmode = dlt_pkg::M_IDENT;
                end else begin
                    d.act  = dlt_pkg::ACT_CONSUME;
                    d.emit = 1'b1;
                    d.kind = dlt_pkg::K_BAD;
                end
            end
        endcase

        // Anything outside idle that consumes or backs off yields a token.
        if (i_mode != dlt_pkg::M_IDLE && d.act != dlt_pkg::ACT_APPEND) d.emit = 1'b1;
        if (d.act == dlt_pkg::ACT_CONSUME) d.len = i_cnt + dlt_pkg::CNT_W'(1);
        if (d.len == '0) d.len = dlt_pkg::CNT_W'(1);
        if (d.act == dlt_pkg::ACT_BACK && d.len > i_cnt)
            d.len = (i_cnt != '0) ? i_cnt : dlt_pkg::CNT_W'(1);

        // A token that would outgrow the buffer is cut here.
        if (d.act == dlt_pkg::ACT_APPEND &&
            i_cnt >= dlt_pkg::CNT_W'(dlt_pkg::LOOKAHEAD_DEPTH - 1)) begin
            d.act  = dlt_pkg::ACT_CONSUME;
            d.emit = 1'b1;
            d.kind = prov;
            d.len  = i_cnt + dlt_pkg::CNT_W'(1);
            d.ovf  = 1'b1;
        end
        o_dec = d;
    end

endmodule

### sv/drawing_language_tokenizer.sv
`timescale 1ns / 1ps
`include "drawing_language_tokenizer_macros.svh"
// ----------------------------------------------------------------------------
// drawing_language_tokenizer
// Streaming scanner for a small drawing language, one text byte per word in,
// one token per word out.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  i_text    in         text_byte (8b), 0 ends the text
//  o_token   out        token_kind, token_start, token_length,
//                       lookahead_overflow, last_of_run
//
// Every byte is written into a circular byte buffer at the address given by
// its stream offset. The pending token sits at the buffer's head and the
// bytes still to be scanned follow it directly, so a rescan after a failed
// string, comment or keyword only moves the read pointer back.
// One byte is judged per cycle unless the output stalls or a held token is flushed;
// rescanned bytes are read back from the buffer, and new text waits while any are pending.
// A step that yields tokens releases its last token from the hold register in a flush step.
// Reset clears the scan state; the buffer needs no clearing pass.
// The output register holds a word until the sink takes it; while it is
// full and stalled, the whole block holds.
module drawing_language_tokenizer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dlt_text_if.sink     i_text,
    dlt_token_if.source  o_token
);

    localparam int CW = dlt_pkg::CNT_W;
    localparam int AW = dlt_pkg::BUF_AW;

    logic [7:0] r_mem [dlt_pkg::BUF_SIZE];
    logic [7:0] r_rdata;

    dlt_pkg::t_mode                    r_mode, n_mode;
    logic [31:0]                       r_start, n_start;
    logic [CW-1:0]                     r_cnt, n_cnt;
    logic [CW-1:0]                     r_qlen, n_qlen;
    logic [dlt_pkg::KEYWORD_COUNT-1:0] r_alive, n_alive;
    logic [1:0]                        r_fs, n_fs;

    // A resolved token waits in the hold register until we know whether
    // another token of the same step follows it.
    logic            r_hold_v;
    dlt_pkg::t_token r_hold;
    logic            r_out_v;
    dlt_pkg::t_token r_out;
    logic            r_out_last;

    logic               enable, from_mem, take_in, proc, flush;
    logic [7:0]         cur_byte;
    logic [CW-1:0]      q_now;
    logic [CW:0]        q_back;
    dlt_pkg::t_decision dec;
    dlt_pkg::t_token    tok;
    logic [AW-1:0]      rd_addr, n_rd_addr;

    assign enable   = !r_out_v || o_token.ready;
    assign from_mem = (r_qlen != '0);
    assign i_text.ready = enable && !from_mem && !r_hold_v;
    assign take_in  = i_text.valid && i_text.ready;
    assign proc     = enable && (from_mem || take_in);
    assign flush    = enable && !from_mem && r_hold_v;
    assign cur_byte = from_mem ? r_rdata : i_text.text_byte;
    assign q_now    = from_mem ? r_qlen : CW'(1);
    assign rd_addr  = r_start[AW-1:0] + r_cnt[AW-1:0];

    dlt_decide u_decide (
        .i_byte  (cur_byte),
        .i_mode  (r_mode),
        .i_cnt   (r_cnt),
        .i_alive (r_alive),
        .i_fs    (r_fs),
        .o_dec   (dec)
    );

    assign tok.kind  = dec.kind;
    assign tok.start = r_start;
    assign tok.len   = dec.len;
    assign tok.ovf   = dec.ovf;
    assign q_back    = {1'b0, q_now} + {1'b0, r_cnt} - {1'b0, dec.len};

    always_comb begin
        n_mode  = r_mode;
        n_start = r_start;
        n_cnt   = r_cnt;
        n_qlen  = r_qlen;
        n_alive = r_alive;
        n_fs    = r_fs;
        if (proc) begin
            unique case (dec.act)
                dlt_pkg::ACT_APPEND: begin
                    n_cnt   = r_cnt + CW'(1);
                    n_qlen  = q_now - CW'(1);
                    n_mode  = dec.nmode;
                    n_alive = dec.nalive;
                    n_fs    = dec.nfs;
                end
                dlt_pkg::ACT_CONSUME: begin
                    n_start = r_start + 32'(r_cnt) + 32'd1;
                    n_cnt   = '0;
                    n_qlen  = q_now - CW'(1);
                    n_mode  = dlt_pkg::M_IDLE;
                    n_alive = '1;
                    n_fs    = '0;
                end
                default: begin
                    // Hand back everything after the emitted token.
                    n_start = r_start + 32'(dec.len);
                    n_cnt   = '0;
                    n_qlen  = q_back[CW-1:0];
                    n_mode  = dlt_pkg::M_IDLE;
                    n_alive = '1;
                    n_fs    = '0;
                end
            endcase
        end
    end

    assign n_rd_addr = n_start[AW-1:0] + n_cnt[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (take_in) r_mem[rd_addr] <= i_text.text_byte;
        if (take_in && rd_addr == n_rd_addr) r_rdata <= i_text.text_byte;
        else r_rdata <= r_mem[n_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= dlt_pkg::M_IDLE;
            r_start  <= '0;
            r_cnt    <= '0;
            r_qlen   <= '0;
            r_alive  <= '1;
            r_fs     <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_cnt   <= n_cnt;
            r_qlen  <= n_qlen;
            r_alive <= n_alive;
            r_fs    <= n_fs;
            if (proc && dec.emit) begin
                r_hold_v <= 1'b1;
                r_out_v  <= r_hold_v || (r_out_v && !o_token.ready);
            end else if (flush) begin
                r_hold_v <= 1'b0;
                r_out_v  <= 1'b1;
            end else begin
                r_out_v  <= r_out_v && !o_token.ready;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && dec.emit) begin
            r_hold <= tok;
            if (r_hold_v) begin
                r_out      <= r_hold;
                r_out_last <= 1'b0;
            end
        end else if (flush) begin
            r_out      <= r_hold;
            r_out_last <= 1'b1;
        end
    end

    assign o_token.valid              = r_out_v;
    assign o_token.token_kind         = r_out.kind;
    assign o_token.token_start        = r_out.start;
    assign o_token.token_length       = dlt_pkg::LEN_W'(r_out.len);
    assign o_token.lookahead_overflow = r_out.ovf;
    assign o_token.last_of_run        = r_out_last;

    `DLT_ASSERT_IMPLY(a_live_fits, i_clk, i_rst_n, 1'b1,
        ({1'b0, r_cnt} + {1'b0, r_qlen} <= (CW+1)'(dlt_pkg::LOOKAHEAD_DEPTH)),
        "buffered bytes exceed the lookahead depth")
    `DLT_ASSERT_IMPLY(a_idle_empty, i_clk, i_rst_n, r_mode == dlt_pkg::M_IDLE,
        r_cnt == '0, "idle scan state with a pending token")
    `DLT_ASSERT_IMPLY(a_hold_len, i_clk, i_rst_n, r_hold_v,
        (r_hold.len != '0) && (r_hold.len <= CW'(dlt_pkg::LOOKAHEAD_DEPTH)),
        "held token has an impossible length")
    `DLT_ASSERT_NEXT(a_flush_last, i_clk, i_rst_n, flush,
        r_out_v && r_out_last && !r_hold_v, "flushed token not marked last")

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the drawing language tokenizer. Text bytes are fed
// through the input channel with random gaps while the token channel stalls
// at random. A scanner model inside the bench predicts every token, and each
// accepted token word is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int RAND_BYTES  = 420;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 200;
    localparam int MAX_TOKENS  = 64;

    typedef enum {A_APPEND, A_TAKE, A_BACK, A_SKIP} t_scan_act;

    typedef struct {
        logic [3:0]  kind;
        logic [31:0] start;
        logic [6:0]  len;
        logic        ovf;
        logic        last;
    } t_token_word;

    typedef struct {
        logic [7:0] b [8];
        int         n;
        bit         chk;
        logic [3:0] kind;
        logic [6:0] len;
    } t_text_row;

    logic i_clk;
    logic i_rst_n;
    dlt_text_if  text_ch ();
    dlt_token_if token_ch ();

    drawing_language_tokenizer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_ch.sink),
        .o_token (token_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Stimulus bytes, with an optional typed token for single-byte rows.
    logic [7:0]  text_q [$];
    bit          typed_chk [$];
    logic [3:0]  typed_kind [$];
    logic [6:0]  typed_len [$];
    t_token_word token_q [$];

    int n_text;
    int text_idx;
    int nx;
    int pause_at;
    int idle_pct;
    int stall_cnt;
    int errors;
    bit accepted;
    t_token_word got;
    t_token_word want;

    // Scanner state kept by the bench.
    logic [7:0]     sc_store [dlt_pkg::LOOKAHEAD_DEPTH];
    dlt_pkg::t_mode sc_mode;
    logic [31:0]    sc_start;
    int             sc_count;
    logic [6:0]     sc_alive;
    logic [1:0]     sc_frac;

    string kw_words [dlt_pkg::KEYWORD_COUNT] = '{
        "#Version", "#Name", "#Author", "#Drawing", "#Region", "#Circle", "#Rect"
    };

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_lower(logic [7:0] c);
        return c >= "a" && c <= "z";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == 8'd32 || c == 8'd10 || c == 8'd9 || c == 8'd8 || c == 8'd12
            || c == 8'd11;
    endfunction

    function automatic void scanner_idle(input int used);
        sc_start = sc_start + used;
        sc_count = 0;
        sc_mode  = dlt_pkg::M_IDLE;
        sc_alive = '1;
        sc_frac  = 2'd0;
    endfunction

    function automatic void push_token(inout int n, input logic [3:0] kind,
                                       input int len, input logic ovf);
        t_token_word w;
        if (n >= MAX_TOKENS) return;
        w.kind  = kind;
        w.start = sc_start;
        w.len   = len[6:0];
        w.ovf   = ovf;
        w.last  = 1'b0;
        token_q.push_back(w);
        n++;
    endfunction

    // Scans one incoming byte plus any bytes a failed lookahead sends back,
    // queueing every token that this byte resolves.
    function automatic void scan_byte(input logic [7:0] b_in);
        logic [7:0]     pend [$];
        logic [7:0]     redo [$];
        logic [7:0]     b;
        logic [6:0]     nalive;
        logic [3:0]     kind, pkind;
        logic [1:0]     nfs;
        dlt_pkg::t_mode nmode;
        t_scan_act      act;
        int             n, cnt, blen;
        n = 0;
        pend.push_back(b_in);
        while (pend.size() > 0) begin
            b      = pend.pop_front();
            cnt    = sc_count;
            act    = A_APPEND;
            kind   = dlt_pkg::K_BAD;
            blen   = 1;
            nmode  = sc_mode;
            nalive = sc_alive;
            nfs    = sc_frac;
            case (sc_mode)
                dlt_pkg::M_KEYWORD: begin
                    if ((cnt == 1) ? (b >= "A" && b <= "Z") : is_lower(b)) begin
                        nalive = '0;
                        for (int i = 0; i < dlt_pkg::KEYWORD_COUNT; i++)
                            if (sc_alive[i] && kw_words[i].len() > cnt && cnt < 9
                                && kw_words[i][cnt] == b)
                                nalive[i] = 1'b1;
                        if (nalive == '0) begin
                            act = A_BACK; kind = dlt_pkg::K_POUND;
                        end
                    end else begin
                        act = A_BACK; kind = dlt_pkg::K_POUND;
                        for (int i = dlt_pkg::KEYWORD_COUNT - 1; i >= 0; i--)
                            if (sc_alive[i] && kw_words[i].len() == cnt) begin
                                kind = i[3:0]; blen = cnt;
                            end
                    end
                end
                dlt_pkg::M_STRING: begin
                    if (b == "]") begin
                        act = A_TAKE; kind = dlt_pkg::K_STRING;
                    end else if (b == 8'd0 || b == 8'd10) begin
                        act = A_BACK;
                    end
                end
                dlt_pkg::M_STAR: begin
                    if (b == "*") nmode = dlt_pkg::M_BLOCK;
                    else if (b == 8'd0 || b == 8'd10) begin
                        act = A_BACK; kind = dlt_pkg::K_COMMENT; blen = cnt;
                    end else nmode = dlt_pkg::M_LINE;
                end
                dlt_pkg::M_LINE: begin
                    if (b == 8'd0 || b == 8'd10) begin
                        act = A_BACK; kind = dlt_pkg::K_COMMENT; blen = cnt;
                    end
                end
                dlt_pkg::M_BLOCK: begin
                    if (b == 8'd0) act = A_BACK;
                    else if (b == "*") nmode = dlt_pkg::M_BLOCK_STAR;
                end
                dlt_pkg::M_BLOCK_STAR: begin
                    if (b == "*") begin
                        act = A_TAKE; kind = dlt_pkg::K_COMMENT;
                    end else if (b == 8'd0) act = A_BACK;
                    else nmode = dlt_pkg::M_BLOCK;
                end
                dlt_pkg::M_NUMBER: begin
                    // A dot needs a digit after it, else the number ends
                    // before the dot.
                    if (sc_frac == 2'd0) begin
                        if (b == ".") nfs = 2'd1;
                        else if (!is_digit(b)) begin
                            act = A_BACK; kind = dlt_pkg::K_NUMBER; blen = cnt;
                        end
                    end else if (sc_frac == 2'd1) begin
                        if (is_digit(b)) nfs = 2'd2;
                        else begin
                            act = A_BACK; kind = dlt_pkg::K_NUMBER;
                            blen = (cnt > 1) ? cnt - 1 : 1;
                        end
                    end else if (!is_digit(b)) begin
                        act = A_BACK; kind = dlt_pkg::K_NUMBER; blen = cnt;
                    end
                end
                dlt_pkg::M_IDENT: begin
                    if (!is_lower(b)) begin
                        act = A_BACK; kind = dlt_pkg::K_IDENT; blen = cnt;
                    end
                end
                default: begin
                    if (is_blank(b)) act = A_SKIP;
                    else if (b == "#") nmode = dlt_pkg::M_KEYWORD;
                    else if (b == "[") nmode = dlt_pkg::M_STRING;
                    else if (b == "*") nmode = dlt_pkg::M_STAR;
                    else if (b == 8'd0) begin
                        act = A_TAKE; kind = dlt_pkg::K_EOF;
                    end else if (b == "=") begin
                        act = A_TAKE; kind = dlt_pkg::K_EQUALS;
                    end else if (b == ".") begin
                        act = A_TAKE; kind = dlt_pkg::K_PERIOD;
                    end else if (is_digit(b) || b == "+" || b == "-") begin
                        nmode = dlt_pkg::M_NUMBER; nfs = 2'd0;
                    end else if (is_lower(b)) nmode = dlt_pkg::M_IDENT;
                    else act = A_TAKE;
                end
            endcase

            if (blen < 1) blen = 1;
            if (act == A_BACK && blen > cnt) blen = (cnt != 0) ? cnt : 1;

            case (act)
                A_SKIP: sc_start = sc_start + 1;
                A_APPEND: begin
                    if (cnt >= dlt_pkg::LOOKAHEAD_DEPTH - 1) begin
                        case (sc_mode)
                            dlt_pkg::M_STRING: pkind = dlt_pkg::K_STRING;
                            dlt_pkg::M_STAR, dlt_pkg::M_LINE, dlt_pkg::M_BLOCK,
                            dlt_pkg::M_BLOCK_STAR: pkind = dlt_pkg::K_COMMENT;
                            dlt_pkg::M_NUMBER: pkind = dlt_pkg::K_NUMBER;
                            dlt_pkg::M_IDENT:  pkind = dlt_pkg::K_IDENT;
                            default:           pkind = dlt_pkg::K_POUND;
                        endcase
                        push_token(n, pkind, cnt + 1, 1'b1);
                        scanner_idle(cnt + 1);
                    end else begin
                        sc_store[cnt] = b;
                        sc_count = cnt + 1;
                        sc_mode  = nmode;
                        sc_alive = nalive;
                        sc_frac  = nfs;
                    end
                end
                A_TAKE: begin
                    push_token(n, kind, cnt + 1, 1'b0);
                    scanner_idle(cnt + 1);
                end
                default: begin
                    // Rescan: the buffered bytes after the emitted part, then
                    // the current byte, then whatever was still waiting.
                    push_token(n, kind, blen, 1'b0);
                    redo.delete();
                    for (int i = blen; i < cnt; i++) redo.push_back(sc_store[i]);
                    redo.push_back(b);
                    while (pend.size() > 0) redo.push_back(pend.pop_front());
                    pend = redo;
                    scanner_idle(blen);
                end
            endcase
        end
        if (n > 0) token_q[token_q.size() - 1].last = 1'b1;
    endfunction

    task automatic add_byte(input logic [7:0] b);
        text_q.push_back(b);
        typed_chk.push_back(1'b0);
        typed_kind.push_back(dlt_pkg::K_BAD);
        typed_len.push_back(7'd0);
    endtask

    task automatic add_text(input string s);
        foreach (s[i]) add_byte(s[i]);
    endtask

    function automatic string lower_run(input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range("a", "z")))};
        return s;
    endfunction

    function automatic string digit_run(input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range("0", "9")))};
        return s;
    endfunction

    // Directed rows: single bytes whose token is plain, then short sequences
    // covering keywords, strings, line comments and numbers.
    t_text_row directed [] = '{
        '{'{"=", 0, 0, 0, 0, 0, 0, 0}, 1, 1'b1, dlt_pkg::K_EQUALS, 7'd1},
        '{'{".", 0, 0, 0, 0, 0, 0, 0}, 1, 1'b1, dlt_pkg::K_PERIOD, 7'd1},
        '{'{8'hFF, 0, 0, 0, 0, 0, 0, 0}, 1, 1'b1, dlt_pkg::K_BAD, 7'd1},
        '{'{8'h0D, 0, 0, 0, 0, 0, 0, 0}, 1, 1'b1, dlt_pkg::K_BAD, 7'd1},
        '{'{8'h00, 0, 0, 0, 0, 0, 0, 0}, 1, 1'b1, dlt_pkg::K_EOF, 7'd1},
        '{'{"#", "R", "e", "c", "t", 8'd9, 0, 0}, 6, 1'b0, dlt_pkg::K_BAD, 7'd0},
        '{'{"[", "a", "]", "#", "N", "x", 0, 0}, 6, 1'b0, dlt_pkg::K_BAD, 7'd0},
        '{'{"*", "z", 8'd10, "+", "1", ".", "x", 0}, 7, 1'b0, dlt_pkg::K_BAD, 7'd0}
    };

    initial begin
        i_rst_n          = 1'b0;
        text_ch.valid    = 1'b0;
        text_ch.text_byte = 8'd0;
        token_ch.ready   = 1'b0;
        errors           = 0;
        stall_cnt        = 0;
        text_idx         = 0;
        scanner_idle(0);
        sc_start = 32'd0;

        foreach (directed[r]) begin
            for (int i = 0; i < directed[r].n; i++) begin
                add_byte(directed[r].b[i]);
                typed_chk[$]  = directed[r].chk;
                typed_kind[$] = directed[r].kind;
                typed_len[$]  = directed[r].len;
            end
        end
        pause_at = text_q.size() + 200;

        // Random part: mostly well-formed tokens with random content, some
        // broken ones and some raw noise.
        while (text_q.size() < pause_at - 200 + RAND_BYTES) begin
            string s;
            int    k;
            case ($urandom_range(0, 19))
                0, 1, 2: begin
                    s = kw_words[$urandom_range(0, dlt_pkg::KEYWORD_COUNT - 1)];
                    if ($urandom_range(0, 3) == 0) begin
                        k = $urandom_range(1, s.len() - 1);
                        s[k] = 8'($urandom_range("A", "z"));
                    end
                    add_text({s, " "});
                end
                3: add_text({"[", lower_run($urandom_range(0, 6)),
                             ($urandom_range(0, 3) == 0) ? "\n" : "]"});
                4: add_text({"*", lower_run($urandom_range(0, 5)), "\n"});
                5: begin
                    add_text({"**", lower_run($urandom_range(0, 5)), "*x"});
                    if ($urandom_range(0, 4) == 0) add_byte(8'd0);
                    else add_text("**");
                end
                6, 7: begin
                    k = $urandom_range(0, 3);
                    s = (k == 0) ? "+" : (k == 1) ? "-" : "";
                    s = {s, digit_run($urandom_range(1, 4))};
                    k = $urandom_range(0, 3);
                    if (k == 0) s = {s, ".", digit_run($urandom_range(1, 3))};
                    else if (k == 1) s = {s, ".", lower_run(1)};
                    add_text({s, " "});
                end
                8, 9: add_text({lower_run($urandom_range(1, 8)), "="});
                10: begin
                    k = $urandom_range(0, 5);
                    add_byte((k == 0) ? 8'd32 : (k == 1) ? 8'd10 : (k == 2) ? 8'd9 :
                             (k == 3) ? 8'd8 : (k == 4) ? 8'd12 : 8'd11);
                end
                11: add_byte(($urandom_range(0, 1) == 0) ? "." : "#");
                12, 13: add_byte(8'($urandom_range(0, 255)));
                14: add_byte(8'd0);
                15: begin
                    // Tokens that may run longer than the lookahead store.
                    if ($urandom_range(0, 3) == 0) begin
                        k = $urandom_range(0, 2);
                        s = lower_run($urandom_range(60, 70));
                        if (k == 1) s = {"[", s, "]"};
                        else if (k == 2) s = {"**", s, "**"};
                        add_text({s, " "});
                    end
                end
                default: add_byte(" ");
            endcase
        end
        n_text = text_q.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // One process drives both channels, runs the scanner model on every
    // accepted text word and checks every accepted token word, so model and
    // checker always see the queue in the same order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            accepted = 1'b0;
            nx = text_idx;
            if (text_ch.valid && text_ch.ready) begin
                accepted = 1'b1;
                scan_byte(text_ch.text_byte);
                if (typed_chk[text_idx]) begin
                    token_q[token_q.size() - 1].kind = typed_kind[text_idx];
                    token_q[token_q.size() - 1].len  = typed_len[text_idx];
                end
                nx = text_idx + 1;
            end
            text_idx = nx;

            if (token_ch.valid && token_ch.ready) begin
                accepted = 1'b1;
                got.kind  = token_ch.token_kind;
                got.start = token_ch.token_start;
                got.len   = token_ch.token_length;
                got.ovf   = token_ch.lookahead_overflow;
                got.last  = token_ch.last_of_run;
                if (token_q.size() == 0) begin
                    report($sformatf("token kind %0d start %0d with nothing expected",
                                     got.kind, got.start));
                end else begin
                    want = token_q.pop_front();
                    if (got.kind != want.kind)
                        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
                    if (got.start != want.start)
                        report($sformatf("start %0d, expected %0d", got.start, want.start));
                    if (got.len != want.len)
                        report($sformatf("length %0d, expected %0d", got.len, want.len));
                    if (got.ovf != want.ovf)
                        report($sformatf("overflow %0b, expected %0b", got.ovf, want.ovf));
                    if (got.last != want.last)
                        report($sformatf("last_of_run %0b, expected %0b",
                                         got.last, want.last));
                end
            end
            stall_cnt = accepted ? 0 : stall_cnt + 1;

            // A quiet stretch with no idling on either side.
            idle_pct = (nx >= pause_at + 60 && nx < pause_at + 160) ? 0 : 24;

            // A word that is waiting stays on the channel until it is taken.
            // The sender holds off once until every predicted token is out.
            if (text_ch.valid && !text_ch.ready) begin
                text_ch.valid <= 1'b1;
            end else if (nx < n_text && !(nx == pause_at && token_q.size() != 0)
                && $urandom_range(0, 99) >= idle_pct) begin
                text_ch.valid     <= 1'b1;
                text_ch.text_byte <= text_q[nx];
            end else begin
                text_ch.valid <= 1'b0;
            end
            token_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    initial begin
        wait (stall_cnt >= STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        wait (i_rst_n === 1'b1);
        wait (text_idx == n_text && token_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (token_q.size() != 0)
            report($sformatf("%0d tokens never arrived", token_q.size()));
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/dlt_pkg.sv
sv/dlt_channels.sv
sv/dlt_decide.sv
sv/drawing_language_tokenizer.sv
bench/tb.sv
